>>> design/offset_reorder_buffer_defines.svh
// Assertion macros used by the reorder buffer module.
`ifndef OFFSET_REORDER_BUFFER_DEFINES_SVH
`define OFFSET_REORDER_BUFFER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ORB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ORB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/orb_pkg.sv
`timescale 1ns / 1ps

package orb_pkg;

  localparam int TAG_W = 16;
  localparam int OFF_W = 48;
  localparam int LEN_W = 17;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_UPSTREAM_FAIL = 2'd1,
    ST_NO_SLOT       = 2'd2,
    ST_ABORTED       = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DIRECT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_STATUS
  } state_t;

  // One parked block descriptor.
  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic [TAG_W-1:0] tag;
  } slot_entry_t;

  // Strobes from the sequencer to the slot store.
  typedef struct packed {
    logic wr;
    logic clr;
    logic rd;
  } slot_ctl_t;

endpackage

>>> design/orb_ifs.sv
`timescale 1ns / 1ps

interface orb_in_if;
  logic                      valid;
  logic                      ready;
  logic [orb_pkg::TAG_W-1:0] buffer_tag;
  logic [orb_pkg::OFF_W-1:0] block_offset;
  logic [orb_pkg::LEN_W-1:0] data_length;
  logic                      end_of_stream;
  logic                      upstream_fail;

  modport source (
    output valid, buffer_tag, block_offset, data_length, end_of_stream, upstream_fail,
    input  ready
  );
  modport sink (
    input  valid, buffer_tag, block_offset, data_length, end_of_stream, upstream_fail,
    output ready
  );
endinterface

interface orb_out_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [orb_pkg::TAG_W-1:0] out_tag;
  logic [orb_pkg::OFF_W-1:0] write_offset;
  logic [orb_pkg::LEN_W-1:0] write_length;
  logic [1:0]                status;
  logic                      stream_ended;
  logic                      last;

  modport source (
    output valid, kind, out_tag, write_offset, write_length, status, stream_ended, last,
    input  ready
  );
  modport sink (
    input  valid, kind, out_tag, write_offset, write_length, status, stream_ended, last,
    output ready
  );
endinterface

>>> design/orb_slot_store.sv
`timescale 1ns / 1ps

module orb_slot_store #(
  parameter int SLOTS = 16,
  parameter int IDX_W = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  orb_pkg::slot_ctl_t   ctl,
  input  logic [IDX_W-1:0]     wr_idx,
  input  logic [IDX_W-1:0]     clr_idx,
  input  logic [IDX_W-1:0]     rd_idx,
  input  orb_pkg::slot_entry_t wr_data,
  output orb_pkg::slot_entry_t rd_data,
  output logic [SLOTS-1:0]     valid_vec,
  output logic                 free_found,
  output logic [IDX_W-1:0]     free_idx
);

  orb_pkg::slot_entry_t mem [SLOTS];
  orb_pkg::slot_entry_t rd_data_r;
  logic [SLOTS-1:0]     valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_idx] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (ctl.wr) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (ctl.clr) begin
        valid_r[clr_idx] <= 1'b0;
      end
    end
  end

  // Lowest free slot wins, so the search runs from the top down.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign rd_data   = rd_data_r;
  assign valid_vec = valid_r;

endmodule

>>> design/offset_reorder_buffer.sv
// The status word of an input that touches no slot is registered in S_STATUS after the
// decision step; a new input is taken only once the block is back in S_IDLE, so inputs are
// handled one at a time. A slot scan pass reads an empty slot in S_SCAN_RD and an occupied
// slot in S_SCAN_RD then S_SCAN_CMP; passes repeat until one writes nothing out, and an
// output stall holds the sequencer in S_DIRECT, in S_SCAN_CMP on a match, or in S_STATUS.
// Reset clears the next offset, all slot valid bits, the end flag and the sticky error.
`timescale 1ns / 1ps
`include "offset_reorder_buffer_defines.svh"

module offset_reorder_buffer #(
  parameter int SLOTS       = 16,
  parameter int BLOCK_BYTES = 65536
) (
  input logic      clk,
  input logic      rst_n,
  orb_in_if.sink   in_chan,
  orb_out_if.source out_chan
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam int BB_W  = $clog2(BLOCK_BYTES + 1);
  localparam int CAP_W = (BB_W > orb_pkg::LEN_W) ? BB_W : orb_pkg::LEN_W;
  localparam logic [CAP_W-1:0] LEN_CAP = CAP_W'(BLOCK_BYTES);

  orb_pkg::state_t state_r, state_nxt;

  logic [orb_pkg::TAG_W-1:0] item_tag_r, item_tag_nxt;
  logic [orb_pkg::OFF_W-1:0] item_off_r, item_off_nxt;
  logic [orb_pkg::LEN_W-1:0] item_len_r, item_len_nxt;
  logic                      item_eos_r, item_eos_nxt;
  logic                      item_fail_r, item_fail_nxt;

  logic [orb_pkg::OFF_W-1:0] next_offset_r, next_offset_nxt;
  logic                      stream_done_r, stream_done_nxt;
  orb_pkg::status_t          sticky_r, sticky_nxt;
  orb_pkg::status_t          err_r, err_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic                      progress_r, progress_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_kind_r, out_kind_nxt;
  logic [orb_pkg::TAG_W-1:0] out_tag_r, out_tag_nxt;
  logic [orb_pkg::OFF_W-1:0] out_off_r, out_off_nxt;
  logic [orb_pkg::LEN_W-1:0] out_len_r, out_len_nxt;
  orb_pkg::status_t          out_status_r, out_status_nxt;
  logic                      out_ended_r, out_ended_nxt;
  logic                      out_last_r, out_last_nxt;

  orb_pkg::slot_ctl_t   slot_ctl;
  orb_pkg::slot_entry_t slot_wr_data;
  orb_pkg::slot_entry_t slot_rd_data;
  logic [SLOTS-1:0]     slot_valid;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;

  logic                      out_free;
  logic                      in_fire;
  logic                      len_over;
  logic [orb_pkg::LEN_W-1:0] len_clamped;
  logic                      slot_match;
  logic                      scan_more;
  logic                      err_sticks;

  orb_slot_store #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_slots (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (slot_ctl),
    .wr_idx     (free_idx),
    .clr_idx    (idx_r),
    .rd_idx     (idx_r),
    .wr_data    (slot_wr_data),
    .rd_data    (slot_rd_data),
    .valid_vec  (slot_valid),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  assign out_free    = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == orb_pkg::S_IDLE);
  assign in_fire     = in_chan.valid && (state_r == orb_pkg::S_IDLE);
  assign len_over    = CAP_W'(in_chan.data_length) > LEN_CAP;
  assign len_clamped = len_over ? LEN_CAP[orb_pkg::LEN_W-1:0] : in_chan.data_length;
  assign slot_match  = (slot_rd_data.offset == next_offset_r);
  assign err_sticks  = (err_r == orb_pkg::ST_UPSTREAM_FAIL) || (err_r == orb_pkg::ST_NO_SLOT);

  assign slot_wr_data.offset = item_off_r;
  assign slot_wr_data.length = item_len_r;
  assign slot_wr_data.tag    = item_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= orb_pkg::S_IDLE;
      next_offset_r <= '0;
      stream_done_r <= 1'b0;
      sticky_r      <= orb_pkg::ST_OK;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      next_offset_r <= next_offset_nxt;
      stream_done_r <= stream_done_nxt;
      sticky_r      <= sticky_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_tag_r   <= item_tag_nxt;
    item_off_r   <= item_off_nxt;
    item_len_r   <= item_len_nxt;
    item_eos_r   <= item_eos_nxt;
    item_fail_r  <= item_fail_nxt;
    err_r        <= err_nxt;
    idx_r        <= idx_nxt;
    progress_r   <= progress_nxt;
    out_kind_r   <= out_kind_nxt;
    out_tag_r    <= out_tag_nxt;
    out_off_r    <= out_off_nxt;
    out_len_r    <= out_len_nxt;
    out_status_r <= out_status_nxt;
    out_ended_r  <= out_ended_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    item_tag_nxt    = item_tag_r;
    item_off_nxt    = item_off_r;
    item_len_nxt    = item_len_r;
    item_eos_nxt    = item_eos_r;
    item_fail_nxt   = item_fail_r;
    next_offset_nxt = next_offset_r;
    stream_done_nxt = stream_done_r;
    sticky_nxt      = sticky_r;
    err_nxt         = err_r;
    idx_nxt         = idx_r;
    progress_nxt    = progress_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_kind_nxt    = out_kind_r;
    out_tag_nxt     = out_tag_r;
    out_off_nxt     = out_off_r;
    out_len_nxt     = out_len_r;
    out_status_nxt  = out_status_r;
    out_ended_nxt   = out_ended_r;
    out_last_nxt    = out_last_r;
    slot_ctl        = '0;
    scan_more       = progress_r;

    unique case (state_r)
      orb_pkg::S_IDLE: begin
        if (in_fire) begin
          item_tag_nxt  = in_chan.buffer_tag;
          item_off_nxt  = in_chan.block_offset;
          item_len_nxt  = len_clamped;
          item_eos_nxt  = in_chan.end_of_stream;
          item_fail_nxt = in_chan.upstream_fail;
          state_nxt     = orb_pkg::S_DECIDE;
        end
      end

      orb_pkg::S_DECIDE: begin
        idx_nxt      = '0;
        progress_nxt = 1'b0;
        if (stream_done_r && (sticky_r != orb_pkg::ST_OK)) begin
          err_nxt   = orb_pkg::ST_ABORTED;
          state_nxt = orb_pkg::S_STATUS;
        end else begin
          stream_done_nxt = stream_done_r || item_fail_r || item_eos_r;
          err_nxt = item_fail_r ? orb_pkg::ST_UPSTREAM_FAIL : orb_pkg::ST_OK;
          if (item_len_r == '0) begin
            state_nxt = orb_pkg::S_STATUS;
          end else if (item_off_r == next_offset_r) begin
            state_nxt = orb_pkg::S_DIRECT;
          end else if (free_found) begin
            slot_ctl.wr = 1'b1;
            state_nxt   = orb_pkg::S_SCAN_RD;
          end else begin
            err_nxt   = orb_pkg::ST_NO_SLOT;
            state_nxt = orb_pkg::S_STATUS;
          end
        end
      end

      orb_pkg::S_DIRECT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = orb_pkg::KIND_WRITE;
          out_tag_nxt     = item_tag_r;
          out_off_nxt     = item_off_r;
          out_len_nxt     = item_len_r;
          out_status_nxt  = orb_pkg::ST_OK;
          out_ended_nxt   = 1'b0;
          out_last_nxt    = 1'b0;
          next_offset_nxt = next_offset_r + orb_pkg::OFF_W'(item_len_r);
          state_nxt       = orb_pkg::S_SCAN_RD;
        end
      end

      orb_pkg::S_SCAN_RD: begin
        if (slot_valid[idx_r]) begin
          slot_ctl.rd = 1'b1;
          state_nxt   = orb_pkg::S_SCAN_CMP;
        end else if (idx_r != LAST_IDX) begin
          idx_nxt = idx_r + 1'b1;
        end else if (scan_more) begin
          idx_nxt      = '0;
          progress_nxt = 1'b0;
        end else begin
          state_nxt = orb_pkg::S_STATUS;
        end
      end

      orb_pkg::S_SCAN_CMP: begin
        // A matching slot waits here until the output register can take it.
        if (!slot_match || out_free) begin
          if (slot_match) begin
            slot_ctl.clr    = 1'b1;
            out_valid_nxt   = 1'b1;
            out_kind_nxt    = orb_pkg::KIND_WRITE;
            out_tag_nxt     = slot_rd_data.tag;
            out_off_nxt     = slot_rd_data.offset;
            out_len_nxt     = slot_rd_data.length;
            out_status_nxt  = orb_pkg::ST_OK;
            out_ended_nxt   = 1'b0;
            out_last_nxt    = 1'b0;
            next_offset_nxt = next_offset_r + orb_pkg::OFF_W'(slot_rd_data.length);
            progress_nxt    = 1'b1;
            scan_more       = 1'b1;
          end
          state_nxt = orb_pkg::S_SCAN_RD;
          if (idx_r != LAST_IDX) begin
            idx_nxt = idx_r + 1'b1;
          end else if (scan_more) begin
            idx_nxt      = '0;
            progress_nxt = 1'b0;
          end else begin
            state_nxt = orb_pkg::S_STATUS;
          end
        end
      end

      orb_pkg::S_STATUS: begin
        if (out_free) begin
          if (err_sticks) begin
            sticky_nxt      = err_r;
            stream_done_nxt = 1'b1;
          end
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = orb_pkg::KIND_STATUS;
          out_tag_nxt    = '0;
          out_off_nxt    = '0;
          out_len_nxt    = '0;
          out_status_nxt = err_r;
          out_ended_nxt  = stream_done_r || err_sticks;
          out_last_nxt   = 1'b1;
          state_nxt      = orb_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = orb_pkg::S_IDLE;
      end
    endcase
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.kind         = out_kind_r;
  assign out_chan.out_tag      = out_tag_r;
  assign out_chan.write_offset = out_off_r;
  assign out_chan.write_length = out_len_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.stream_ended = out_ended_r;
  assign out_chan.last         = out_last_r;

  `ORB_ASSERT_NEXT(a_accept_decides,
                   in_chan.valid && in_chan.ready,
                   state_r == orb_pkg::S_DECIDE,
                   "accepted word did not move to the decision step")
  `ORB_ASSERT_NOW(a_cmp_slot_valid,
                  state_r == orb_pkg::S_SCAN_CMP,
                  slot_valid[idx_r],
                  "comparing a slot that is not occupied")
  `ORB_ASSERT_NOW(a_sticky_ends,
                  sticky_r != orb_pkg::ST_OK,
                  stream_done_r,
                  "sticky error held without the stream being ended")
  `ORB_ASSERT_NEXT(a_status_last,
                   state_r == orb_pkg::S_STATUS && out_free,
                   out_valid_r && out_last_r && (out_kind_r == orb_pkg::KIND_STATUS),
                   "status word not presented as the final word")

endmodule
